// ----- rtl/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// b64e_pkg: shared types and constants of the base64 line wrapping encoder
// Command codes, register indexes, alphabet lookup and fixed character codes.
// ----------------------------------------------------------------------------
package b64e_pkg;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_reg_idx;
    typedef logic [7:0] t_char;

    // Request commands
    localparam t_cmd CMD_DATA = 2'd0;  // raw byte
    localparam t_cmd CMD_END  = 2'd1;  // flush leftover bytes with padding
    localparam t_cmd CMD_CLR  = 2'd2;  // drop pending bytes, clear line count

    // Register indexes
    localparam t_reg_idx REG_LINE_LEN = 2'd0;
    localparam t_reg_idx REG_NL_LEN   = 2'd1;
    localparam t_reg_idx REG_NL_FIRST = 2'd2;
    localparam t_reg_idx REG_NL_SECOND = 2'd3;

    localparam int CFG_W     = 16;
    localparam int GROUP_LEN = 4;   // characters per encoded group
    localparam int NL_CHARS  = 2;   // newline characters that exist

    localparam t_char CHAR_PAD = 8'h3D;  // '='

    // Reset values of the registers
    localparam logic [15:0] LINE_LEN_RST  = 16'd76;
    localparam logic [1:0]  NL_LEN_RST    = 2'd2;
    localparam t_char       NL_FIRST_RST  = 8'h0D;
    localparam t_char       NL_SECOND_RST = 8'h0A;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic t_char b64_char(input logic [5:0] v);
        t_char c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

// ----- rtl/b64e_if.sv -----
// ----------------------------------------------------------------------------
// b64e_if: request channels of the base64 line wrapping encoder
// Input channel carries command and byte, output channel one character.
// ----------------------------------------------------------------------------
interface b64e_in_if;
    logic                valid;
    logic                ready;
    b64e_pkg::t_cmd      cmd;
    logic [7:0]          data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface b64e_out_if;
    logic                valid;
    logic                ready;
    b64e_pkg::t_char     out_char;
    logic                last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

// ----- rtl/base64_line_wrapping_encoder_top.sv -----
// ----------------------------------------------------------------------------
// base64_line_wrapping_encoder_top: streaming base64 encoder with line wrap
// Takes one byte or command per request and emits base64 characters,
// '=' padding and newline sequences, one character per cycle while o_out is ready.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  -------   ---  ---------------  ----------------------------------------
//  i_in      in   valid / ready    cmd[1:0], data_byte[7:0]
//  o_out     out  valid / ready    out_char[7:0], last (final char of request)
//  i_cfg_*   in   write enable     i_cfg_idx[1:0], i_cfg_data[15:0]
//
//  A request is decoded in the cycle it is taken; its characters (up to
//  4 + min(NEWLINE_MAX, 2), at most 6) load a shift buffer and leave one per
//  cycle while o_out is ready. The buffer drain sets the rate: the next
//  first byte is taken as the last character of a group leaves, and the
//  two held bytes of a group are taken with no output in between.
//  A request with no output is taken whenever the buffer is empty.
//  A new request is taken in the cycle the last buffered character leaves.
//  Reset is synchronous: registers return to 76 / 2 / CR / LF, count clear.
//
module base64_line_wrapping_encoder_top #(
    parameter int NEWLINE_MAX = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    b64e_in_if.sink                       i_in,
    b64e_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  b64e_pkg::t_reg_idx            i_cfg_idx,
    input  logic [b64e_pkg::CFG_W-1:0]    i_cfg_data
);
    import b64e_pkg::*;

    // Newline characters that can actually appear, and buffer depth
    localparam int NL_CAP    = (NEWLINE_MAX < NL_CHARS) ? NEWLINE_MAX : NL_CHARS;
    localparam int BUF_DEPTH = GROUP_LEN + NL_CAP;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // Configuration registers
    logic [15:0] r_line_len;
    logic [1:0]  r_nl_len;
    t_char       r_nl_first;
    t_char       r_nl_second;

    // Encoder state
    logic [7:0]  r_pend0, r_pend1;     // no reset: read only under the count
    logic [1:0]  r_pend_cnt, n_pend_cnt;
    logic [7:0]  n_pend0, n_pend1;
    logic [15:0] r_col, n_col;
    logic        r_wrote_any, n_wrote_any;

    // Output shift buffer
    t_char            r_buf [BUF_DEPTH];
    t_char            n_load [BUF_DEPTH];
    logic [CNT_W-1:0] r_cnt;

    logic        w_acc, w_take, w_emit;
    logic [1:0]  w_nl_lim, w_nl_len, w_nl_n;
    logic        w_nl_due;
    logic [1:0]  w_nvalid;
    logic [7:0]  w_b1, w_b2;
    logic [23:0] w_word;
    t_char       w_grp [GROUP_LEN];
    logic [15:0] w_col4;

    // ---------------- handshakes ----------------
    assign w_take       = o_out.valid && o_out.ready;
    // free now, or the last buffered character leaves this cycle
    assign i_in.ready   = (r_cnt == '0) || (o_out.ready && r_cnt == CNT_W'(1));
    assign w_acc        = i_in.valid && i_in.ready;

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_char = r_buf[0];
    assign o_out.last     = (r_cnt == CNT_W'(1));

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len  <= LINE_LEN_RST;
            r_nl_len    <= NL_LEN_RST;
            r_nl_first  <= NL_FIRST_RST;
            r_nl_second <= NL_SECOND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LINE_LEN:  r_line_len  <= i_cfg_data;
                REG_NL_LEN:    r_nl_len    <= i_cfg_data[1:0];
                REG_NL_FIRST:  r_nl_first  <= i_cfg_data[7:0];
                REG_NL_SECOND: r_nl_second <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------- newline check ----------------
    // length 3 folds to 2, then to the parameter cap
    assign w_nl_lim = (r_nl_len > 2'(NL_CHARS)) ? 2'(NL_CHARS) : r_nl_len;
    assign w_nl_len = (w_nl_lim > 2'(NL_CAP)) ? 2'(NL_CAP) : w_nl_lim;
    assign w_nl_due = (r_line_len != 16'd0) && r_wrote_any && (r_col == 16'd0);
    assign w_nl_n   = w_nl_due ? w_nl_len : 2'd0;

    // line count after a full group; wraps at 16 bits when wrapping is off
    assign w_col4 = r_col + 16'd4;

    // ---------------- request decode ----------------
    always_comb begin
        n_pend_cnt  = r_pend_cnt;
        n_pend0     = r_pend0;
        n_pend1     = r_pend1;
        n_col       = r_col;
        n_wrote_any = r_wrote_any;
        w_emit      = 1'b0;
        w_nvalid    = 2'd3;
        w_b1        = r_pend1;
        w_b2        = i_in.data_byte;
        unique case (i_in.cmd)
            CMD_DATA: begin
                if (r_pend_cnt == 2'd0) begin
                    n_pend0    = i_in.data_byte;
                    n_pend_cnt = 2'd1;
                end else if (r_pend_cnt == 2'd1) begin
                    n_pend1    = i_in.data_byte;
                    n_pend_cnt = 2'd2;
                end else begin
                    // third byte completes a group
                    w_emit      = 1'b1;
                    n_pend_cnt  = 2'd0;
                    n_wrote_any = 1'b1;
                    if (r_line_len != 16'd0 && w_col4 >= r_line_len) begin
                        n_col = 16'd0;
                    end else begin
                        n_col = w_col4;
                    end
                end
            end
            CMD_END: begin
                if (r_pend_cnt != 2'd0) begin
                    // padded group; line count untouched
                    w_emit     = 1'b1;
                    w_nvalid   = r_pend_cnt;
                    w_b1       = (r_pend_cnt == 2'd2) ? r_pend1 : 8'h00;
                    w_b2       = 8'h00;
                    n_pend_cnt = 2'd0;
                end
            end
            CMD_CLR: begin
                n_pend_cnt  = 2'd0;
                n_col       = 16'd0;
                n_wrote_any = 1'b0;
            end
            default: ;  // unused command: no effect
        endcase
    end

    // ---------------- group encode ----------------
    assign w_word   = {r_pend0, w_b1, w_b2};
    assign w_grp[0] = b64_char(w_word[23:18]);
    assign w_grp[1] = b64_char(w_word[17:12]);
    assign w_grp[2] = (w_nvalid >= 2'd2) ? b64_char(w_word[11:6]) : CHAR_PAD;
    assign w_grp[3] = (w_nvalid == 2'd3) ? b64_char(w_word[5:0]) : CHAR_PAD;

    // newline characters first, then the four group characters
    always_comb begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            if (i < int'(w_nl_n)) begin
                n_load[i] = (i == 0) ? r_nl_first : r_nl_second;
            end else if (i - int'(w_nl_n) < GROUP_LEN) begin
                n_load[i] = w_grp[2'(i - int'(w_nl_n))];
            end else begin
                n_load[i] = 8'h00;
            end
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt  <= 2'd0;
            r_col       <= 16'd0;
            r_wrote_any <= 1'b0;
        end else if (w_acc) begin
            r_pend_cnt  <= n_pend_cnt;
            r_col       <= n_col;
            r_wrote_any <= n_wrote_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pend0 <= n_pend0;
            r_pend1 <= n_pend1;
        end
    end

    // ---------------- output buffer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_acc && w_emit) begin
            r_cnt <= CNT_W'(w_nl_n) + CNT_W'(GROUP_LEN);
        end else if (w_take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_emit) begin
            r_buf <= n_load;
        end else if (w_take) begin
            for (int i = 0; i < BUF_DEPTH - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

`ifndef SYNTHESIS
    // a request is taken over a busy buffer only as its last character leaves
    a_accept_when_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_cnt != '0) |-> (o_out.ready && r_cnt == CNT_W'(1)))
        else $error("request taken while buffer still holds characters");

    // pending count never reaches three
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt != 2'd3)
        else $error("pending byte count out of range");

    // a completed group shows up on the output in the next cycle
    a_group_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.cmd == CMD_DATA && r_pend_cnt == 2'd2) |=> o_out.valid)
        else $error("full group did not reach the output");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of base64_line_wrapping_encoder_top
// Directed rows, then randomized byte streams under several line and newline
// settings, with random gaps and stalls on both channels; each output character
// is checked against typed-in characters or an in-bench encoder model.
// ----------------------------------------------------------------------------
module testbench;
    import b64e_pkg::*;

    localparam int   NL_MAX       = 2;           // DUT NEWLINE_MAX
    localparam t_cmd CMD_UNUSED   = 2'd3;        // decoded as a no-op
    localparam int   DRAIN_CYCLES = 8;           // settle time before a register write
    localparam int   PHASE_ITEMS  = 60;          // counted requests per random phase
    localparam int   NUM_PHASES   = 6;

    // Alphabet packed MSB first: sextet v sits at bits [8*(63-v) +: 8]
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef enum logic [1:0] {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    // One stimulus row: a request (code = cmd, value[7:0] = byte) or a
    // register write (code = index). Rows with fixed set carry their
    // expected characters typed in; the rest go through the model.
    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  code;
        logic [15:0] value;
        logic        fixed;
        logic [2:0]  fixed_n;
        logic [31:0] fixed_chars;
    } t_stim_row;

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_enc_char;

    logic clk;
    logic rst_n;
    logic cfg_we;
    t_reg_idx cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    b64e_in_if  in_ch ();
    b64e_out_if out_ch ();

    base64_line_wrapping_encoder_top #(
        .NEWLINE_MAX (NL_MAX)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Encoder model state and register copies
    // ------------------------------------------------------------------
    logic [15:0] line_len;
    logic [1:0]  nl_len;
    t_char       nl_first;
    t_char       nl_second;

    logic [7:0]  held_byte0;
    logic [7:0]  held_byte1;
    logic [1:0]  held_count;
    logic [15:0] line_col;
    logic        group_written;

    t_char       step_chars [6];      // characters caused by the last request
    int          step_n;

    t_enc_char   expected_chars [$];  // characters still owed by the DUT
    int          error_count;
    logic        no_idle;             // burst mode: no gaps, no stalls
    int          stall_left;

    t_stim_row   directed_rows [$];

    // ------------------------------------------------------------------
    // Clock and output-side backpressure
    // ------------------------------------------------------------------
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    initial begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0 && !no_idle) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else begin
                out_ch.ready = 1'b1;
                stall_left   = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Model: characters per request
    // ------------------------------------------------------------------
    function automatic t_char sextet_char(input logic [5:0] v);
        return ALPHABET[8*(63 - v) +: 8];
    endfunction

    task automatic add_char(input t_char c);
        step_chars[step_n] = c;
        step_n++;
    endtask

    // Newline goes out ahead of a group only at a line boundary, once a full
    // group has been written, and only when wrapping is on.
    task automatic add_newline_if_due();
        int n;
        if (line_len != 16'd0 && group_written && line_col == 16'd0) begin
            n = (nl_len > NL_CHARS) ? NL_CHARS : int'(nl_len);
            if (n > NL_MAX) n = NL_MAX;
            if (n > 0) add_char(nl_first);
            if (n > 1) add_char(nl_second);
        end
    endtask

    // valid_n: bytes that are real (1..3); the others become '=' padding
    task automatic add_group(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input int valid_n);
        logic [23:0] w;
        w = {b0, b1, b2};
        add_char(sextet_char(w[23:18]));
        add_char(sextet_char(w[17:12]));
        add_char(valid_n >= 2 ? sextet_char(w[11:6]) : CHAR_PAD);
        add_char(valid_n >= 3 ? sextet_char(w[5:0]) : CHAR_PAD);
    endtask

    task automatic encode_request(input t_cmd op, input logic [7:0] b);
        step_n = 0;
        case (op)
            CMD_DATA: begin
                if (held_count == 2'd0) begin
                    held_byte0 = b;
                    held_count = 2'd1;
                end else if (held_count == 2'd1) begin
                    held_byte1 = b;
                    held_count = 2'd2;
                end else begin
                    add_newline_if_due();
                    add_group(held_byte0, held_byte1, b, 3);
                    held_count    = 2'd0;
                    group_written = 1'b1;
                    line_col      = line_col + 16'd4;   // wraps at 16 bits
                    // a length that is not a multiple of 4 wraps once passed
                    if (line_len != 16'd0 && line_col >= line_len) line_col = 16'd0;
                end
            end
            CMD_END: begin
                // padded groups leave the line count alone
                if (held_count != 2'd0) begin
                    add_newline_if_due();
                    if (held_count == 2'd1) begin
                        add_group(held_byte0, 8'h00, 8'h00, 1);
                    end else begin
                        add_group(held_byte0, held_byte1, 8'h00, 2);
                    end
                    held_count = 2'd0;
                end
            end
            CMD_CLR: begin
                held_count    = 2'd0;
                line_col      = 16'd0;
                group_written = 1'b0;
            end
            default: begin
                // unused code: no effect, no output
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus rows
    // ------------------------------------------------------------------
    function automatic t_stim_row req_row(input t_cmd op, input logic [7:0] b);
        t_stim_row r;
        r             = '0;
        r.kind        = ROW_REQ;
        r.code        = op;
        r.value       = {8'h00, b};
        return r;
    endfunction

    function automatic t_stim_row req_fixed(input t_cmd op, input logic [7:0] b,
                                            input int n, input logic [31:0] chars);
        t_stim_row r;
        r             = req_row(op, b);
        r.fixed       = 1'b1;
        r.fixed_n     = n[2:0];
        r.fixed_chars = chars;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input t_reg_idx idx, input logic [15:0] v);
        t_stim_row r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.code  = idx;
        r.value = v;
        return r;
    endfunction

    // Block is idle once nothing is owed and any no-output request has passed.
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] v);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_we   = 1'b0;
        case (idx)
            REG_LINE_LEN:  line_len  = v;
            REG_NL_LEN:    nl_len    = v[1:0];
            REG_NL_FIRST:  nl_first  = v[7:0];
            REG_NL_SECOND: nl_second = v[7:0];
            default: begin end
        endcase
    endtask

    task automatic issue_row(input t_stim_row r);
        int gap;
        int i;
        if (r.kind == ROW_CFG) begin
            wait_idle();
            write_reg(t_reg_idx'(r.code), r.value);
        end else begin
            gap = pick_gap();
            if (gap > 0) begin
                @(negedge clk);
                in_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            in_ch.valid     = 1'b1;
            in_ch.cmd       = t_cmd'(r.code);
            in_ch.data_byte = r.value[7:0];
            do @(posedge clk); while (!in_ch.ready);
            // request taken at this edge: the model always advances
            encode_request(t_cmd'(r.code), r.value[7:0]);
            if (r.fixed) begin
                for (i = 0; i < int'(r.fixed_n); i++) begin
                    expected_chars.push_back({r.fixed_chars[31 - 8*i -: 8],
                                              i == int'(r.fixed_n) - 1});
                end
            end else begin
                for (i = 0; i < step_n; i++) begin
                    expected_chars.push_back({step_chars[i], i == step_n - 1});
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output checker: one character per accepted output request
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_enc_char e;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character, expected none, actual %h last %b",
                         $time, out_ch.out_char, out_ch.last);
                error_count++;
            end else begin
                e = expected_chars.pop_front();
                if (out_ch.out_char !== e.ch) begin
                    $display("%0t: out_char mismatch, expected %h, actual %h",
                             $time, e.ch, out_ch.out_char);
                    error_count++;
                end
                if (out_ch.last !== e.last) begin
                    $display("%0t: last mismatch, expected %b, actual %b",
                             $time, e.last, out_ch.last);
                    error_count++;
                end
            end
        end
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int p;
        int counted;
        int r;
        t_cmd op;

        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_DATA;
        in_ch.data_byte = 8'h00;
        cfg_we          = 1'b0;
        cfg_idx         = REG_LINE_LEN;
        cfg_data        = '0;
        error_count     = 0;
        no_idle         = 1'b0;

        // model in its reset state
        line_len      = LINE_LEN_RST;
        nl_len        = NL_LEN_RST;
        nl_first      = NL_FIRST_RST;
        nl_second     = NL_SECOND_RST;
        held_byte0    = 8'h00;
        held_byte1    = 8'h00;
        held_count    = 2'd0;
        line_col      = 16'd0;
        group_written = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Defaults after reset: 76 per line, CR LF. No newline comes before
        // the first group, and none mid-line.
        directed_rows.push_back(req_fixed(CMD_UNUSED, 8'hA5, 0, 32'h0));  // no-op code
        directed_rows.push_back(req_fixed(CMD_END,    8'h00, 0, 32'h0));  // end, nothing held
        directed_rows.push_back(req_fixed(CMD_DATA,   8'h00, 0, 32'h0));
        directed_rows.push_back(req_fixed(CMD_DATA,   8'h00, 0, 32'h0));
        directed_rows.push_back(req_fixed(CMD_DATA,   8'h00, 4, "AAAA"));
        directed_rows.push_back(req_fixed(CMD_DATA,   8'hFF, 0, 32'h0));
        directed_rows.push_back(req_fixed(CMD_DATA,   8'hFF, 0, 32'h0));
        directed_rows.push_back(req_fixed(CMD_DATA,   8'hFF, 4, "////"));
        directed_rows.push_back(req_fixed(CMD_DATA,   8'hFF, 0, 32'h0));
        directed_rows.push_back(req_fixed(CMD_END,    8'h00, 4, "/w=="));  // one byte left
        directed_rows.push_back(req_fixed(CMD_DATA,   8'hFF, 0, 32'h0));
        directed_rows.push_back(req_fixed(CMD_DATA,   8'hFF, 0, 32'h0));
        directed_rows.push_back(req_fixed(CMD_END,    8'h00, 4, "//8="));  // two bytes left
        directed_rows.push_back(req_fixed(CMD_CLR,    8'h00, 0, 32'h0));
        // Shortest line, oversized newline length (acts as 2), extreme chars
        directed_rows.push_back(cfg_row(REG_LINE_LEN,  16'd4));
        directed_rows.push_back(cfg_row(REG_NL_LEN,    16'd3));
        directed_rows.push_back(cfg_row(REG_NL_FIRST,  16'h0000));
        directed_rows.push_back(cfg_row(REG_NL_SECOND, 16'h00FF));
        directed_rows.push_back(req_row(CMD_DATA, 8'h4D));
        directed_rows.push_back(req_row(CMD_DATA, 8'h61));
        directed_rows.push_back(req_row(CMD_DATA, 8'h6E));
        directed_rows.push_back(req_row(CMD_DATA, 8'h00));
        directed_rows.push_back(req_row(CMD_DATA, 8'hFF));
        directed_rows.push_back(req_row(CMD_DATA, 8'h7F));  // newline + group: 6 chars
        directed_rows.push_back(req_row(CMD_DATA, 8'h80));
        directed_rows.push_back(req_row(CMD_END,  8'h00));  // newline ahead of padding

        foreach (directed_rows[k]) issue_row(directed_rows[k]);

        // Random phases. No clear between phases, so a new line length
        // lands on a stream that is already part way through a line.
        for (p = 0; p < NUM_PHASES; p++) begin
            no_idle = (p == 2);
            case (p)
                0: issue_row(cfg_row(REG_LINE_LEN, 16'd0));       // wrapping off
                1: issue_row(cfg_row(REG_LINE_LEN, 16'd8));
                2: issue_row(cfg_row(REG_LINE_LEN, 16'd6));       // not a multiple of 4
                3: issue_row(cfg_row(REG_LINE_LEN, 16'd65532));   // largest multiple of 4
                4: issue_row(cfg_row(REG_LINE_LEN, 16'd4));
                default: issue_row(cfg_row(REG_LINE_LEN, 16'(4 * $urandom_range(3, 20))));
            endcase
            issue_row(cfg_row(REG_NL_LEN,    16'(p % 4)));
            issue_row(cfg_row(REG_NL_FIRST,  16'($urandom_range(0, 255))));
            issue_row(cfg_row(REG_NL_SECOND, 16'($urandom_range(0, 255))));

            counted = 0;
            while (counted < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 82) begin
                    op = CMD_DATA;
                end else if (r < 91) begin
                    op = CMD_END;
                end else if (r < 95) begin
                    op = CMD_CLR;
                end else begin
                    op = CMD_UNUSED;
                end
                issue_row(req_row(op, 8'($urandom_range(0, 255))));
                if (op != CMD_UNUSED) counted++;
            end
        end

        no_idle = 1'b0;
        wait_idle();

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
